// ----- sv/enst_pkg.sv -----
// ----------------------------------------------------------------------------
// enst_pkg
// Shared codes, field widths and control types of the node status table.
// ----------------------------------------------------------------------------
package enst_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned GID_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 11;

  localparam logic [CMD_W-1:0] CMD_SET_GROUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INFECT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DETECT    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RECOVER   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_SUSCEPTIBLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INFECTED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DETECTED    = 2'd2;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_UP,
    CNT_DOWN
  } cnt_op_e;

  typedef struct packed {
    logic                changed;
    logic [STATUS_W-1:0] status;
    logic                set_mark;
    cnt_op_e             inf_op;
    cnt_op_e             det_op;
    cnt_op_e             rec_op;
  } upd_ctrl_t;

endpackage

// ----- sv/epidemic_node_status_table.sv -----
// ----------------------------------------------------------------------------
// epidemic_node_status_table
// Per-node status table with per-group infected, detected and recovered
// counters, updated by one node command at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  command   in         start / busy                  cmd_i, node_i, group_id_i
//  result    out        result_valid_o (1 cycle)      changed_o, new_status_o,
//                                                     *_total_o
//  config    in         cfg_valid_i / cfg_ready_o     cfg_data_i (track_recov)
//
//  Each item runs through accept and node memory read, group counter read
//  at the group found there, then update and write back of both memories.
//  The result strobe comes the cycle after; a new command may be accepted
//  in that same cycle. After reset a clearing pass over every address
//  zeroes both memories while busy is high.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module epidemic_node_status_table
  import enst_pkg::*;
#(
  parameter int unsigned NODES  = 1024,
  parameter int unsigned GROUPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [NODE_W-1:0]   node_i,
  input  logic [GID_W-1:0]    group_id_i,
  output logic                result_valid_o,
  output logic                changed_o,
  output logic [STATUS_W-1:0] new_status_o,
  output logic [TOTAL_W-1:0]  infected_total_o,
  output logic [TOTAL_W-1:0]  detected_total_o,
  output logic [TOTAL_W-1:0]  recovered_total_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int unsigned NIDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned CNT_W  = $clog2(NODES + 1);
  localparam int unsigned WORD_W = 1 + GIDX_W + STATUS_W;
  localparam int unsigned SWEEP  = (NODES > GROUPS) ? NODES : GROUPS;
  localparam int unsigned SW_W   = $clog2(SWEEP);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_NODE  = 2'd2;
  localparam logic [1:0] S_GROUP = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SW_W-1:0]   clr_q, clr_d;
  logic              track_recov_q;
  logic              accept;

  logic [CMD_W-1:0]  cmd_q;
  logic [NODE_W-1:0] node_q;
  logic [GID_W-1:0]  gid_q;
  logic              in_range_q;
  logic [GIDX_W-1:0] grp_q;

  logic [WORD_W-1:0] node_rd;
  logic              old_mark;
  logic [GIDX_W-1:0] old_grp;
  logic [STATUS_W-1:0] old_status;
  logic [GIDX_W-1:0] grp_sel;

  logic              node_we;
  logic [NIDX_W-1:0] node_waddr;
  logic [WORD_W-1:0] node_wdata;
  logic              grp_we;
  logic              clearing;
  logic [GIDX_W-1:0] grp_waddr;

  upd_ctrl_t         ctrl;
  logic [CNT_W-1:0]  inf_new, det_new, rec_new;

  logic                result_valid_q;
  logic                changed_q;
  logic [STATUS_W-1:0] new_status_q;
  logic [TOTAL_W-1:0]  inf_total_q, det_total_q, rec_total_q;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign clearing    = (state_q == S_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_recov_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      track_recov_q <= cfg_data_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + SW_W'(1);
        if (clr_q == SW_W'(SWEEP - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_NODE;
        end
      end
      S_NODE:  state_d = S_GROUP;
      S_GROUP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      node_q     <= node_i;
      gid_q      <= group_id_i;
      in_range_q <= (32'(node_i) < NODES);
    end
    if (state_q == S_NODE) begin
      grp_q <= grp_sel;
    end
  end

  assign old_status = node_rd[STATUS_W-1:0];
  assign old_grp    = node_rd[STATUS_W +: GIDX_W];
  assign old_mark   = node_rd[WORD_W-1];

  // set group takes effect before the counters are read
  assign grp_sel = ((cmd_q == CMD_SET_GROUP) && (32'(gid_q) < GROUPS)) ?
                   GIDX_W'(gid_q) : old_grp;

  enst_update u_update (
    .cmd_i         (cmd_q),
    .status_i      (old_status),
    .track_recov_i (track_recov_q),
    .ctrl_o        (ctrl)
  );

  assign node_we    = (clearing && (32'(clr_q) < NODES)) ||
                      ((state_q == S_GROUP) && in_range_q);
  assign node_waddr = clearing ? NIDX_W'(clr_q) : NIDX_W'(node_q);
  assign node_wdata = clearing ? '0 : {old_mark | ctrl.set_mark, grp_q, ctrl.status};

  enst_node_store #(
    .DEPTH  (NODES),
    .ADDR_W (NIDX_W),
    .WORD_W (WORD_W)
  ) u_node_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (NIDX_W'(node_i)),
    .rd_data_o (node_rd),
    .wr_en_i   (node_we),
    .wr_addr_i (node_waddr),
    .wr_data_i (node_wdata)
  );

  assign grp_we    = (clearing && (32'(clr_q) < GROUPS)) ||
                     ((state_q == S_GROUP) && in_range_q);
  assign grp_waddr = clearing ? GIDX_W'(clr_q) : grp_q;

  enst_group_store #(
    .DEPTH  (GROUPS),
    .ADDR_W (GIDX_W),
    .CNT_W  (CNT_W),
    .NODES  (NODES)
  ) u_group_store (
    .clk_i     (clk_i),
    .rd_en_i   (state_q == S_NODE),
    .rd_addr_i (grp_sel),
    .wr_en_i   (grp_we),
    .clr_i     (clearing),
    .wr_addr_i (grp_waddr),
    .ctrl_i    (ctrl),
    .inf_o     (inf_new),
    .det_o     (det_new),
    .rec_o     (rec_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= (state_q == S_GROUP);
    end
  end

  // out-of-range node reports all zero
  always_ff @(posedge clk_i) begin
    if (state_q == S_GROUP) begin
      changed_q    <= in_range_q & ctrl.changed;
      new_status_q <= in_range_q ? ctrl.status : ST_SUSCEPTIBLE;
      inf_total_q  <= in_range_q ? TOTAL_W'(inf_new) : '0;
      det_total_q  <= in_range_q ? TOTAL_W'(det_new) : '0;
      rec_total_q  <= in_range_q ? TOTAL_W'(rec_new) : '0;
    end
  end

  assign result_valid_o    = result_valid_q;
  assign changed_o         = changed_q;
  assign new_status_o      = new_status_q;
  assign infected_total_o  = inf_total_q;
  assign detected_total_o  = det_total_q;
  assign recovered_total_o = rec_total_q;

  a_accept_reads_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_NODE))
    else $error("accepted command did not start a node read");

  a_result_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROUP) |=> result_valid_o)
    else $error("write back without result strobe");

  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (new_status_o <= ST_DETECTED))
    else $error("illegal status reported");

endmodule

// ----- sv/enst_node_store.sv -----
// ----------------------------------------------------------------------------
// enst_node_store
// Per-node memory: recovered mark, group number and status, one word each.
// ----------------------------------------------------------------------------
module enst_node_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned WORD_W = 7
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/enst_group_store.sv -----
// ----------------------------------------------------------------------------
// enst_group_store
// Per-group counter memory with saturating read-modify-write update.
// ----------------------------------------------------------------------------
module enst_group_store
  import enst_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned CNT_W  = 11,
  parameter int unsigned NODES  = 1024
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic              clr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  upd_ctrl_t         ctrl_i,
  output logic [CNT_W-1:0]  inf_o,
  output logic [CNT_W-1:0]  det_o,
  output logic [CNT_W-1:0]  rec_o
);

  localparam int unsigned          WORD_W  = 3 * CNT_W;
  localparam logic [CNT_W-1:0]     CNT_MAX = CNT_W'(NODES);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] wr_data;

  function automatic logic [CNT_W-1:0] apply_op(logic [CNT_W-1:0] c, cnt_op_e op);
    logic [CNT_W-1:0] r;
    r = c;
    case (op)
      CNT_UP:   r = (c >= CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
      CNT_DOWN: r = (c == '0) ? '0 : c - CNT_W'(1);
      default:  r = c;
    endcase
    return r;
  endfunction

  assign inf_o = apply_op(rd_data_q[CNT_W-1:0], ctrl_i.inf_op);
  assign det_o = apply_op(rd_data_q[2*CNT_W-1:CNT_W], ctrl_i.det_op);
  assign rec_o = apply_op(rd_data_q[3*CNT_W-1:2*CNT_W], ctrl_i.rec_op);

  assign wr_data = clr_i ? '0 : {rec_o, det_o, inf_o};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

endmodule

// ----- sv/enst_update.sv -----
// ----------------------------------------------------------------------------
// enst_update
// Status transition rules: next status, changed flag and counter moves.
// ----------------------------------------------------------------------------
module enst_update
  import enst_pkg::*;
(
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic                track_recov_i,
  output upd_ctrl_t           ctrl_o
);

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.status   = status_i;
    ctrl_o.inf_op   = CNT_HOLD;
    ctrl_o.det_op   = CNT_HOLD;
    ctrl_o.rec_op   = CNT_HOLD;
    unique case (cmd_i)
      CMD_INFECT: begin
        if (status_i == ST_SUSCEPTIBLE) begin
          ctrl_o.status  = ST_INFECTED;
          ctrl_o.inf_op  = CNT_UP;
          ctrl_o.changed = 1'b1;
        end
      end
      CMD_DETECT: begin
        if (status_i == ST_INFECTED) begin
          ctrl_o.status  = ST_DETECTED;
          ctrl_o.det_op  = CNT_UP;
          ctrl_o.changed = 1'b1;
        end
      end
      CMD_RECOVER: begin
        if (status_i != ST_SUSCEPTIBLE) begin
          ctrl_o.status  = ST_SUSCEPTIBLE;
          ctrl_o.inf_op  = CNT_DOWN;
          ctrl_o.changed = 1'b1;
          // only a detected node leaves the detected count
          if (status_i == ST_DETECTED) begin
            ctrl_o.det_op = CNT_DOWN;
          end
          if (track_recov_i) begin
            ctrl_o.set_mark = 1'b1;
            ctrl_o.rec_op   = CNT_UP;
          end
        end
      end
      default: begin
        ctrl_o.status = status_i;
      end
    endcase
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the node status table. A queue of node commands
// is issued through start/busy with random idle cycles, a local copy of the
// node and group tables predicts every result, and each result strobe is
// checked field by field in order. The stimulus covers the command corners,
// a full sweep of all nodes to drive a group's infected counter to its
// ceiling, and random traffic on a small node pool with recovery tracking
// in both states.
// ----------------------------------------------------------------------------
module testbench;
  import enst_pkg::*;

  localparam int unsigned NODES        = 1024;
  localparam int unsigned GROUPS       = 16;
  localparam int unsigned POOL_SIZE    = 16;
  localparam int unsigned RANDOM_ITEMS = 360;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node;
    logic [GID_W-1:0]  gid;
  } node_cmd_t;

  typedef struct packed {
    logic                changed;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  infected;
    logic [TOTAL_W-1:0]  detected;
    logic [TOTAL_W-1:0]  recovered;
  } node_upd_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i       = CMD_SET_GROUP;
  logic [NODE_W-1:0]   node_i      = '0;
  logic [GID_W-1:0]    group_id_i  = '0;
  logic                result_valid_o;
  logic                changed_o;
  logic [STATUS_W-1:0] new_status_o;
  logic [TOTAL_W-1:0]  infected_total_o;
  logic [TOTAL_W-1:0]  detected_total_o;
  logic [TOTAL_W-1:0]  recovered_total_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i  = 1'b0;

  // local copy of the tables
  logic [STATUS_W-1:0] status_tab [NODES];
  logic                mark_tab   [NODES];
  logic [GID_W-1:0]    group_tab  [NODES];
  logic [TOTAL_W-1:0]  inf_cnt    [GROUPS];
  logic [TOTAL_W-1:0]  det_cnt    [GROUPS];
  logic [TOTAL_W-1:0]  rec_cnt    [GROUPS];
  logic                keep_rec = 1'b0;

  node_cmd_t   cmd_backlog_q[$];
  node_upd_t   due_updates_q[$];
  int unsigned idle_left    = 0;
  int unsigned quiet_left   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned changed_cnt  = 0;
  int unsigned ceiling_cnt  = 0;
  int unsigned cfg_cnt      = 0;
  int unsigned mismatch_cnt = 0;

  epidemic_node_status_table #(
    .NODES  (NODES),
    .GROUPS (GROUPS)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cmd_i             (cmd_i),
    .node_i            (node_i),
    .group_id_i        (group_id_i),
    .result_valid_o    (result_valid_o),
    .changed_o         (changed_o),
    .new_status_o      (new_status_o),
    .infected_total_o  (infected_total_o),
    .detected_total_o  (detected_total_o),
    .recovered_total_o (recovered_total_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [TOTAL_W-1:0] count_inc(logic [TOTAL_W-1:0] c);
    return (c >= NODES) ? TOTAL_W'(NODES) : c + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] count_dec(logic [TOTAL_W-1:0] c);
    return (c == '0) ? '0 : c - 1'b1;
  endfunction

  function automatic node_upd_t predict_node_update(logic [CMD_W-1:0] cmd,
      logic [NODE_W-1:0] node, logic [GID_W-1:0] gid);
    node_upd_t           upd = '0;
    logic [STATUS_W-1:0] was;
    logic [GID_W-1:0]    grp;
    if (node >= NODES) return upd;
    was = status_tab[node];
    if (cmd == CMD_SET_GROUP && gid < GROUPS) group_tab[node] = gid;
    grp = group_tab[node];
    case (cmd)
      CMD_INFECT: begin
        if (was == ST_SUSCEPTIBLE) begin
          status_tab[node] = ST_INFECTED;
          inf_cnt[grp]     = count_inc(inf_cnt[grp]);
          upd.changed      = 1'b1;
        end
      end
      CMD_DETECT: begin
        if (was == ST_INFECTED) begin
          status_tab[node] = ST_DETECTED;
          det_cnt[grp]     = count_inc(det_cnt[grp]);
          upd.changed      = 1'b1;
        end
      end
      CMD_RECOVER: begin
        if (was != ST_SUSCEPTIBLE) begin
          status_tab[node] = ST_SUSCEPTIBLE;
          inf_cnt[grp]     = count_dec(inf_cnt[grp]);
          if (was == ST_DETECTED) det_cnt[grp] = count_dec(det_cnt[grp]);
          if (keep_rec) begin
            mark_tab[node] = 1'b1;
            rec_cnt[grp]   = count_inc(rec_cnt[grp]);
          end
          upd.changed = 1'b1;
        end
      end
      default: ;
    endcase
    upd.status    = status_tab[node];
    upd.infected  = inf_cnt[grp];
    upd.detected  = det_cnt[grp];
    upd.recovered = rec_cnt[grp];
    return upd;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, int unsigned node, int unsigned gid);
    cmd_backlog_q.push_back('{cmd: cmd, node: NODE_W'(node), gid: GID_W'(gid)});
  endtask

  task automatic present_cmd();
    node_cmd_t c = cmd_backlog_q.pop_front();
    cmd_i      <= c.cmd;
    node_i     <= c.node;
    group_id_i <= c.gid;
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd();
    int unsigned r = $urandom_range(0, 99);
    if (r < 20) return CMD_SET_GROUP;
    if (r < 50) return CMD_INFECT;
    if (r < 75) return CMD_DETECT;
    return CMD_RECOVER;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_backlog_q.size() != 0 || start || due_updates_q.size() != 0);
  endtask

  task automatic write_track_recov(logic value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    keep_rec = value;
    cfg_cnt++;
  endtask

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               checked_cnt, what, want, got);
  endtask

  // command issue: one transfer per start && !busy edge, random idle between
  always @(posedge clk_i) begin : cmd_drive
    int unsigned gap;
    if (rst_ni) begin
      if (start) begin
        if (!busy) begin
          due_updates_q.push_back(predict_node_update(cmd_i, node_i, group_id_i));
          accepted_cnt++;
          if (quiet_left != 0) begin
            gap = 0;
            quiet_left--;
          end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(20, 60);
          end
          // hold start high straight into the next command
          if (gap == 0 && cmd_backlog_q.size() != 0) begin
            present_cmd();
          end else begin
            start     <= 1'b0;
            idle_left <= gap;
          end
        end
      end else if (idle_left != 0) begin
        idle_left <= idle_left - 1;
      end else if (cmd_backlog_q.size() != 0) begin
        present_cmd();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    node_upd_t want;
    if (rst_ni && result_valid_o) begin
      checked_cnt++;
      if (changed_o === 1'b1) changed_cnt++;
      if (infected_total_o == NODES || detected_total_o == NODES ||
          recovered_total_o == NODES) ceiling_cnt++;
      if (due_updates_q.size() == 0) begin
        flag_mismatch("unexpected result, changed", 0, changed_o);
      end else begin
        want = due_updates_q.pop_front();
        if (changed_o !== want.changed)
          flag_mismatch("changed", want.changed, changed_o);
        if (new_status_o !== want.status)
          flag_mismatch("new_status", want.status, new_status_o);
        if (infected_total_o !== want.infected)
          flag_mismatch("infected_total", want.infected, infected_total_o);
        if (detected_total_o !== want.detected)
          flag_mismatch("detected_total", want.detected, detected_total_o);
        if (recovered_total_o !== want.recovered)
          flag_mismatch("recovered_total", want.recovered, recovered_total_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned base;
    int unsigned n;
    int unsigned gid;
    int unsigned pool [POOL_SIZE];
    for (int k = 0; k < NODES; k++) begin
      status_tab[k] = ST_SUSCEPTIBLE;
      mark_tab[k]   = 1'b0;
      group_tab[k]  = '0;
    end
    for (int k = 0; k < GROUPS; k++) begin
      inf_cnt[k] = '0;
      det_cnt[k] = '0;
      rec_cnt[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // command corners, recovery not kept
    write_track_recov(1'b0);
    queue_cmd(CMD_INFECT,    0,    15);
    queue_cmd(CMD_INFECT,    0,    0);
    queue_cmd(CMD_DETECT,    1023, 0);
    queue_cmd(CMD_DETECT,    0,    7);
    queue_cmd(CMD_DETECT,    0,    0);
    queue_cmd(CMD_SET_GROUP, 1023, 15);
    queue_cmd(CMD_INFECT,    1023, 0);
    queue_cmd(CMD_RECOVER,   1023, 0);
    queue_cmd(CMD_RECOVER,   1023, 9);
    // move a detected node: counters stay behind, recover floors at zero
    queue_cmd(CMD_SET_GROUP, 0,    15);
    queue_cmd(CMD_RECOVER,   0,    0);
    queue_cmd(CMD_INFECT,    0,    0);
    queue_cmd(CMD_SET_GROUP, 0,    0);
    wait_idle();

    // recovery kept
    write_track_recov(1'b1);
    queue_cmd(CMD_DETECT,    0,    3);
    queue_cmd(CMD_RECOVER,   0,    12);
    queue_cmd(CMD_SET_GROUP, 682,  10);
    queue_cmd(CMD_INFECT,    682,  5);
    queue_cmd(CMD_DETECT,    682,  5);
    queue_cmd(CMD_RECOVER,   682,  10);
    queue_cmd(CMD_SET_GROUP, 341,  5);
    queue_cmd(CMD_INFECT,    341,  10);
    queue_cmd(CMD_RECOVER,   341,  5);
    wait_idle();

    // sweep every node into group 0 and infect it
    base = $urandom_range(0, NODES - 1);
    for (int k = 0; k < NODES; k++) begin
      n = (base + k) % NODES;
      if (status_tab[n] != ST_SUSCEPTIBLE) queue_cmd(CMD_RECOVER, n, $urandom);
      if (group_tab[n] != '0) queue_cmd(CMD_SET_GROUP, n, 0);
      queue_cmd(CMD_INFECT, n, $urandom);
    end
    // bounce a few nodes through another group so group 0 tries to count past its ceiling
    for (int k = 0; k < 3; k++) begin
      n   = $urandom_range(0, NODES - 1);
      gid = $urandom_range(1, GROUPS - 1);
      queue_cmd(CMD_SET_GROUP, n, gid);
      queue_cmd(CMD_RECOVER,   n, $urandom);
      queue_cmd(CMD_SET_GROUP, n, 0);
      queue_cmd(CMD_INFECT,    n, $urandom);
      queue_cmd(CMD_DETECT,    n, $urandom);
    end
    for (int k = 0; k < 3; k++) begin
      n = $urandom_range(0, NODES - 1);
      queue_cmd(CMD_INFECT,  n, $urandom);
      queue_cmd(CMD_RECOVER, n, $urandom);
    end

    // random traffic on a small pool of nodes, a tenth anywhere
    for (int half = 0; half < 2; half++) begin
      wait_idle();
      write_track_recov(half[0]);
      for (int k = 0; k < POOL_SIZE; k++) pool[k] = $urandom_range(0, NODES - 1);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NODES - 1)
                                          : pool[$urandom_range(0, POOL_SIZE - 1)];
        gid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, GROUPS - 1)
                                          : $urandom_range(0, 3);
        queue_cmd(pick_cmd(), n, gid);
      end
    end
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("summary: %0d commands, %0d results checked, %0d recovery-tracking writes",
             accepted_cnt, checked_cnt, cfg_cnt);
    $display("summary: %0d status changes, %0d results at a full group counter, %0d mismatches",
             changed_cnt, ceiling_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/enst_pkg.sv
sv/enst_node_store.sv
sv/enst_group_store.sv
sv/enst_update.sv
sv/epidemic_node_status_table.sv
bench/testbench.sv
